// File: design/prrts_pkg.sv
// Package for the priority / round-robin task scheduler.
// Holds sizes, state and action codes, config indexes and small helper functions.
// No dependencies.
package prrts_pkg;

    localparam int TASK_SLOTS      = 16;
    localparam int PRIORITY_LEVELS = 8;

    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int LVL_W      = $clog2(PRIORITY_LEVELS);
    localparam int ACTION_W   = 2;
    localparam int TIDX_W     = 4;
    localparam int TSTATE_W   = 3;
    localparam int TPRIO_W    = 3;
    localparam int DELAY_W    = 32;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [TPRIO_W-1:0]   PRIO_RESET = 3'd7;

    localparam logic [TSTATE_W-1:0]  TS_INVALID = 3'd0;
    localparam logic [TSTATE_W-1:0]  TS_UNRUN   = 3'd1;
    localparam logic [TSTATE_W-1:0]  TS_READY   = 3'd2;
    localparam logic [TSTATE_W-1:0]  TS_DELAYED = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_SCHED = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_DONE
    } fsm_t;

    function automatic logic is_runnable(input logic [TSTATE_W-1:0] s);
        return (s == TS_UNRUN) || (s == TS_READY);
    endfunction

    function automatic logic [LVL_W-1:0] lvl_of(input logic [TPRIO_W-1:0] p);
        if (32'(p) < PRIORITY_LEVELS) begin
            return LVL_W'(p);
        end else begin
            return LVL_W'(PRIORITY_LEVELS - 1);
        end
    endfunction

endpackage

// File: design/priority_round_robin_task_scheduler_unit.sv
// Top level of the priority / round-robin task scheduler.
// Task table, one-slot-per-cycle scan sequencer and result register.
// Depends on prrts_pkg.
//
// Usage:
//   Input channel (s_*): one beat per item. action 0 loads a task slot, action 1
//   asks for the next task, action 2 is a timer tick, action 3 does nothing.
//   Result channel (m_*): exactly one beat per input beat, in order. found and
//   chosen_task are nonzero only for a schedule that picked a runnable task.
//   Config channel (cfg_*): always ready; index 0 sets priority_mode, index 1
//   sets active_tasks. Write it only while no item is in flight.
// Sequencing:
//   Write and no-op items go from accept straight to the done state; tick
//   items scan all TASK_SLOTS slots, schedule items scan then pass a finish
//   state. A single scan counter walks the table one slot per cycle, sharing
//   one decrementer and one level compare, and s_ready is low from accept
//   until the result reaches the output register: one item in flight at a time.
// Reset: table goes to invalid state, priority 7; current task and
//   last-served indexes clear; priority_mode = 1, active_tasks = 0.
// Stall: a held result sits in the output register; the next item is still
//   accepted and its scan runs, then waits until the output register frees.
module priority_round_robin_task_scheduler_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [prrts_pkg::ACTION_W-1:0]       s_action,
    input  logic [prrts_pkg::TIDX_W-1:0]         s_task_index,
    input  logic [prrts_pkg::TSTATE_W-1:0]       s_task_state,
    input  logic [prrts_pkg::TPRIO_W-1:0]        s_task_priority,
    input  logic [prrts_pkg::DELAY_W-1:0]        s_delay_ticks,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic [prrts_pkg::TIDX_W-1:0]         m_chosen_task,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [prrts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prrts_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import prrts_pkg::*;

    logic [TSTATE_W-1:0] state_tab_reg [TASK_SLOTS];
    logic [TPRIO_W-1:0]  prio_tab_reg  [TASK_SLOTS];
    logic [DELAY_W-1:0]  delay_tab_reg [TASK_SLOTS];
    logic [IDX_W-1:0]    last_served_reg [PRIORITY_LEVELS];
    logic [IDX_W-1:0]    current_reg;
    logic                prio_mode_reg;
    logic [ACTIVE_W-1:0] active_reg;

    fsm_t                fsm_reg, fsm_next;
    action_t             action_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    steps_reg;
    logic                hit_reg;
    logic [LVL_W-1:0]    best_reg;
    logic [IDX_W-1:0]    first_reg;
    logic [IDX_W-1:0]    after_reg;
    logic                has_after_reg;
    logic                res_found_reg;
    logic [TIDX_W-1:0]   res_task_reg;
    logic                m_valid_reg;
    logic                m_found_reg;
    logic [TIDX_W-1:0]   m_task_reg;

    logic                accept;
    logic                wr_ok;
    logic [IDX_W-1:0]    wr_idx;
    logic [TSTATE_W-1:0] cur_state;
    logic [LVL_W-1:0]    cur_lvl;
    logic                cur_run;
    logic                in_active;
    logic                slot_after;
    logic [DELAY_W-1:0]  dec;
    logic                last_step;
    logic [IDX_W-1:0]    slot_inc;
    logic [IDX_W-1:0]    rr_start;
    logic [IDX_W-1:0]    pick;
    logic                out_load;

    assign accept     = s_valid && s_ready;
    assign wr_ok      = 32'(s_task_index) < TASK_SLOTS;
    assign wr_idx     = IDX_W'(s_task_index);
    assign cur_state  = state_tab_reg[slot_reg];
    assign cur_lvl    = lvl_of(prio_tab_reg[slot_reg]);
    assign cur_run    = is_runnable(cur_state);
    assign in_active  = 32'(slot_reg) < 32'(active_reg);
    assign slot_after = slot_reg > last_served_reg[cur_lvl];
    assign dec        = delay_tab_reg[slot_reg] - DELAY_W'(1);
    assign last_step  = steps_reg == IDX_W'(TASK_SLOTS - 1);
    assign slot_inc   = (slot_reg == IDX_W'(TASK_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    assign rr_start   = (current_reg == IDX_W'(TASK_SLOTS - 1)) ? '0 : current_reg + 1'b1;
    assign pick       = has_after_reg ? after_reg : first_reg;

    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_chosen_task = m_task_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg <= ST_IDLE;
        end else begin
            fsm_reg <= fsm_next;
        end
    end

    always_comb begin
        fsm_next = fsm_reg;
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (fsm_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (action_t'(s_action))
                        ACT_SCHED: fsm_next = ST_SCAN;
                        ACT_TICK:  fsm_next = ST_SCAN;
                        default:   fsm_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (last_step) begin
                    fsm_next = (action_reg == ACT_SCHED) ? ST_FIN : ST_DONE;
                end
            end
            ST_FIN: begin
                fsm_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    fsm_next = ST_IDLE;
                end
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_mode_reg <= 1'b1;
            active_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PRIO_MODE: prio_mode_reg <= cfg_data[0];
                CFG_ACTIVE:    active_reg    <= cfg_data[ACTIVE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                state_tab_reg[i] <= TS_INVALID;
                prio_tab_reg[i]  <= PRIO_RESET;
            end
        end else begin
            if (accept && action_t'(s_action) == ACT_WRITE && wr_ok) begin
                state_tab_reg[wr_idx] <= s_task_state;
                prio_tab_reg[wr_idx]  <= s_task_priority;
            end
            if (fsm_reg == ST_SCAN && action_reg == ACT_TICK && cur_state == TS_DELAYED
                && dec == '0) begin
                state_tab_reg[slot_reg] <= TS_READY;
            end
            if (fsm_reg == ST_FIN && hit_reg) begin
                state_tab_reg[pick] <= TS_READY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && action_t'(s_action) == ACT_WRITE && wr_ok) begin
            delay_tab_reg[wr_idx] <= s_delay_ticks;
        end
        if (fsm_reg == ST_SCAN && action_reg == ACT_TICK && cur_state == TS_DELAYED) begin
            delay_tab_reg[slot_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_reg <= '0;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                last_served_reg[i] <= '0;
            end
        end else if (fsm_reg == ST_FIN && hit_reg) begin
            current_reg <= pick;
            if (prio_mode_reg) begin
                last_served_reg[best_reg] <= pick;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg    <= action_t'(s_action);
            steps_reg     <= '0;
            slot_reg      <= (action_t'(s_action) == ACT_SCHED && !prio_mode_reg) ?
                             rr_start : '0;
            hit_reg       <= 1'b0;
            has_after_reg <= 1'b0;
            res_found_reg <= 1'b0;
            res_task_reg  <= '0;
        end else if (fsm_reg == ST_SCAN) begin
            steps_reg <= steps_reg + 1'b1;
            slot_reg  <= slot_inc;
            if (action_reg == ACT_SCHED && prio_mode_reg) begin
                if (cur_run && in_active) begin
                    if (!hit_reg || cur_lvl < best_reg) begin
                        hit_reg       <= 1'b1;
                        best_reg      <= cur_lvl;
                        first_reg     <= slot_reg;
                        after_reg     <= slot_reg;
                        has_after_reg <= slot_after;
                    end else if (cur_lvl == best_reg && !has_after_reg && slot_after) begin
                        after_reg     <= slot_reg;
                        has_after_reg <= 1'b1;
                    end
                end
            end else if (action_reg == ACT_SCHED) begin
                if (cur_run && !hit_reg) begin
                    hit_reg   <= 1'b1;
                    first_reg <= slot_reg;
                end
            end
        end else if (fsm_reg == ST_FIN) begin
            res_found_reg <= hit_reg;
            res_task_reg  <= hit_reg ? TIDX_W'(pick) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg <= res_found_reg;
            m_task_reg  <= res_task_reg;
        end
    end

endmodule

// File: design/prrts_checker.sv
// Port-level checker for the task scheduler top level, with its bind statement.
// Depends on prrts_pkg and priority_round_robin_task_scheduler_unit.
module prrts_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_found,
    input logic [prrts_pkg::TIDX_W-1:0]     m_chosen_task
);
    import prrts_pkg::*;

    // result register empties on reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // held result beat does not change
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_chosen_task))
        else $error("stalled result beat changed");

    // one item in flight: busy right after an input beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous item in flight");

    // a result without a pick reports slot zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_chosen_task == TIDX_W'(0))
        else $error("chosen_task nonzero without found");

endmodule

bind priority_round_robin_task_scheduler_unit prrts_checker u_prrts_checker (.*);
